/* hdl/iol_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the indexed ordered list.
// No dependencies; imported by iol_cell and the top module of the block.
package iol_pkg;

    localparam int CAPACITY_DEF    = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int ACTION_W   = 2;
    localparam int POS_W      = 5;
    localparam int VAL_PORT_W = 32;
    localparam int STATUS_W   = 2;
    localparam int FOUND_W    = 5;
    localparam int COUNT_W    = 5;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_FIND   = 2'd2
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_BAD_INDEX = 2'd1,
        STAT_FULL      = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic shift_up;
        logic shift_down;
    } t_cell_ctl;

    localparam logic [FOUND_W-1:0] FOUND_NONE = '1;

endpackage

/* hdl/iol_cell.sv */
`timescale 1ns / 1ps
// One list cell: holds one entry, shifts with its neighbours, flags a match.
// Depends on iol_pkg.
module iol_cell #(
    parameter int IDX         = 0,
    parameter int CNT_W       = 5,
    parameter int CMP_W       = 5,
    parameter int VALUE_WIDTH = iol_pkg::VALUE_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  iol_pkg::t_cell_ctl         i_ctl,
    input  logic [iol_pkg::POS_W-1:0]  i_pos,
    input  logic [CNT_W-1:0]           i_count,
    input  logic [VALUE_WIDTH-1:0]     i_value,
    input  logic [VALUE_WIDTH-1:0]     i_left,
    input  logic [VALUE_WIDTH-1:0]     i_right,
    output logic [VALUE_WIDTH-1:0]     o_data,
    output logic                       o_match
);
    import iol_pkg::*;

    localparam logic [CMP_W-1:0] L_IDX = CMP_W'(IDX);

    logic [VALUE_WIDTH-1:0] r_data;
    logic                   r_match;
    logic [CMP_W-1:0]       pos_c;
    logic [CMP_W-1:0]       cnt_c;

    assign pos_c = CMP_W'(i_pos);
    assign cnt_c = CMP_W'(i_count);

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift_up) begin
            if (L_IDX > pos_c) begin
                r_data <= i_left;
            end else if (L_IDX == pos_c) begin
                r_data <= i_value;
            end
        end else if (i_ctl.shift_down && (L_IDX >= pos_c)) begin
            r_data <= i_right;
        end
        r_match <= (L_IDX < cnt_c) && (r_data == i_value);
    end

    assign o_data  = r_data;
    assign o_match = r_match;

endmodule

/* hdl/iol_prienc.sv */
`timescale 1ns / 1ps
// Priority encoder: lowest set match flag wins.
// No dependencies.
module iol_prienc #(
    parameter int N     = 16,
    parameter int IDX_W = 4
) (
    input  logic [N-1:0]     i_match,
    output logic             o_hit,
    output logic [IDX_W-1:0] o_index
);
    always_comb begin
        o_index = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (i_match[i]) begin
                o_index = IDX_W'(i);
            end
        end
    end

    assign o_hit = |i_match;

endmodule

/* hdl/indexed_ordered_list_top.sv */
`timescale 1ns / 1ps
// Indexed ordered list: control, chain of cells and result register.
// Depends on iol_pkg, iol_cell and iol_prienc.
//
//  channel  | handshake           | fields
//  ---------+---------------------+--------------------------------------------
//  command  | start / busy        | i_action, i_position, i_value
//  result   | o_valid (strobe)    | o_status, o_found_index, o_removed_value,
//           |                     | o_count_after
//
// A beat is taken when start is high and busy is low; busy stays high for the
// following cycle while the cells shift, and no beat is taken while it is high.
// The result passes from the exec state through r_pend to the output registers;
// the result strobe is high for one cycle, together with the result fields.
// Reset (synchronous) empties the list; entry contents are left as they are.
// The receiver cannot stall: each result is shown once and then dropped.
module indexed_ordered_list_top #(
    parameter int CAPACITY    = iol_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = iol_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [iol_pkg::ACTION_W-1:0]        i_action,
    input  logic [iol_pkg::POS_W-1:0]           i_position,
    input  logic [iol_pkg::VAL_PORT_W-1:0]      i_value,
    output logic                                o_valid,
    output logic [iol_pkg::STATUS_W-1:0]        o_status,
    output logic signed [iol_pkg::FOUND_W-1:0]  o_found_index,
    output logic [iol_pkg::VAL_PORT_W-1:0]      o_removed_value,
    output logic [iol_pkg::COUNT_W-1:0]         o_count_after
);
    import iol_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    t_state                 r_state, n_state;
    logic [ACTION_W-1:0]    r_act;
    logic [POS_W-1:0]       r_pos;
    logic [VALUE_WIDTH-1:0] r_val;
    logic [CNT_W-1:0]       r_count, n_count;
    logic                   r_pend;
    logic                   r_is_find;
    logic [STATUS_W-1:0]    r_status, n_status;
    logic [VALUE_WIDTH-1:0] r_removed, n_removed;

    t_cell_ctl              cell_ctl;
    logic                   take;
    logic                   rem_ok;
    logic [CMP_W-1:0]       pos_c;
    logic [CMP_W-1:0]       cnt_c;
    logic [VALUE_WIDTH-1:0] w_data [CAPACITY];
    logic [CAPACITY-1:0]    w_match;
    logic                   enc_hit;
    logic [IDX_W-1:0]       enc_index;

    assign busy  = (r_state == S_EXEC);
    assign take  = start && (r_state == S_IDLE);
    assign pos_c = CMP_W'(r_pos);
    assign cnt_c = CMP_W'(r_count);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_status = STAT_OK;
        cell_ctl = '0;
        rem_ok   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                case (t_action'(r_act))
                    ACT_INSERT: begin
                        if (pos_c > cnt_c) begin
                            n_status = STAT_BAD_INDEX;
                        end else if (r_count == CNT_W'(CAPACITY)) begin
                            n_status = STAT_FULL;
                        end else begin
                            cell_ctl.shift_up = 1'b1;
                            n_count = r_count + 1'b1;
                        end
                    end
                    ACT_REMOVE: begin
                        if (pos_c >= cnt_c) begin
                            n_status = STAT_BAD_INDEX;
                        end else begin
                            cell_ctl.shift_down = 1'b1;
                            rem_ok  = 1'b1;
                            n_count = r_count - 1'b1;
                        end
                    end
                    ACT_FIND: begin
                        n_status = STAT_OK;
                    end
                    default: begin
                        n_status = STAT_BAD_INDEX;
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_removed = rem_ok ? w_data[pos_c[IDX_W-1:0]] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= (r_state == S_EXEC);
            o_valid <= r_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_act <= i_action;
            r_pos <= i_position;
            r_val <= VALUE_WIDTH'(i_value);
        end
        if (r_state == S_EXEC) begin
            r_status  <= n_status;
            r_removed <= n_removed;
            r_is_find <= (r_act == ACT_FIND);
        end
        if (r_pend) begin
            o_status        <= r_status;
            o_removed_value <= VAL_PORT_W'(r_removed);
            o_count_after   <= COUNT_W'(r_count);
            if (!r_is_find) begin
                o_found_index <= '0;
            end else if (enc_hit) begin
                o_found_index <= FOUND_W'(enc_index);
            end else begin
                o_found_index <= FOUND_NONE;
            end
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [VALUE_WIDTH-1:0] left_d;
        logic [VALUE_WIDTH-1:0] right_d;

        if (g == 0) begin : g_first
            assign left_d = r_val;
        end else begin : g_mid
            assign left_d = w_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign right_d = '0;
        end else begin : g_inner
            assign right_d = w_data[g+1];
        end

        iol_cell #(
            .IDX         (g),
            .CNT_W       (CNT_W),
            .CMP_W       (CMP_W),
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (cell_ctl),
            .i_pos   (r_pos),
            .i_count (r_count),
            .i_value (r_val),
            .i_left  (left_d),
            .i_right (right_d),
            .o_data  (w_data[g]),
            .o_match (w_match[g])
        );
    end

    iol_prienc #(
        .N     (CAPACITY),
        .IDX_W (IDX_W)
    ) u_prienc (
        .i_match (w_match),
        .o_hit   (enc_hit),
        .o_index (enc_index)
    );

`ifndef SYNTHESIS
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##3 o_valid)
        else $error("command beat gave no result");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == STAT_FULL)) |-> (o_count_after == COUNT_W'(CAPACITY)))
        else $error("full status with room left");

    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != STAT_OK)) |-> (o_removed_value == '0))
        else $error("removed value on a failed action");
`endif

endmodule
